/* rtl/lrhp_pkg.sv */
// Shared types and constants for the log record header parser.
// No dependencies.
`timescale 1ns / 1ps

package lrhp_pkg;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SEQ    = 2'd1;
  localparam logic [1:0] PH_DELTA  = 2'd2;
  localparam logic [1:0] PH_MSG    = 2'd3;

  localparam int DISC_BIT = 6;

  localparam logic REC_MSG = 1'b0;
  localparam logic REC_END = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  msg;
    logic [2:0]  level;
    logic [31:0] seq;
    logic [55:0] delta;
    logic        last;
  } rec_t;

endpackage

/* rtl/lrhp_parse.sv */
// Packet parse state and per-byte record logic for the log record header parser.
// Depends on lrhp_pkg.
`timescale 1ns / 1ps

module lrhp_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    byte_in,
  input  logic          eop,
  output logic          res_valid,
  output lrhp_pkg::rec_t res
);
  import lrhp_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [31:0] seq_counter, seq_counter_next;
  logic [31:0] seq_shadow, seq_shadow_next;
  logic [2:0]  level_reg, level_reg_next;
  logic [2:0]  delta_len, delta_len_next;
  logic [55:0] delta_acc, delta_acc_next;
  logic [2:0]  bc_inc;

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    seq_counter_next = seq_counter;
    seq_shadow_next  = seq_shadow;
    level_reg_next   = level_reg;
    delta_len_next   = delta_len;
    delta_acc_next   = delta_acc;
    bc_inc           = byte_count + 3'd1;
    res_valid        = 1'b0;
    res.kind         = REC_END;
    res.msg          = 8'd0;
    res.last         = 1'b1;
    unique case (phase)
      PH_HEADER: begin
        level_reg_next  = byte_in[2:0];
        delta_len_next  = byte_in[5:3];
        delta_acc_next  = '0;
        seq_shadow_next = '0;
        byte_count_next = '0;
        if (byte_in[DISC_BIT]) begin
          phase_next = PH_SEQ;
        end else begin
          seq_counter_next = seq_counter + 32'd1;
          phase_next = (byte_in[5:3] == 3'd0) ? PH_MSG : PH_DELTA;
          res_valid  = eop && (byte_in[5:3] == 3'd0);
        end
      end
      PH_SEQ: begin
        seq_shadow_next = seq_shadow | (32'(byte_in) << {byte_count[1:0], 3'b000});
        byte_count_next = bc_inc;
        if (bc_inc[2]) begin
          seq_counter_next = seq_shadow_next + 32'd1;
          byte_count_next  = '0;
          phase_next = (delta_len == 3'd0) ? PH_MSG : PH_DELTA;
          res_valid  = eop && (delta_len == 3'd0);
        end
      end
      PH_DELTA: begin
        delta_acc_next  = delta_acc | (56'(byte_in) << {byte_count, 3'b000});
        byte_count_next = bc_inc;
        if (bc_inc >= delta_len) begin
          byte_count_next = '0;
          phase_next      = PH_MSG;
          res_valid       = eop;
        end
      end
      PH_MSG: begin
        res_valid = 1'b1;
        res.kind  = REC_MSG;
        res.msg   = byte_in;
        res.last  = eop;
      end
      default: ;
    endcase
    if (eop) begin
      phase_next      = PH_HEADER;
      byte_count_next = '0;
    end
    res.level = level_reg_next;
    res.seq   = seq_counter_next;
    res.delta = delta_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      byte_count  <= '0;
      seq_counter <= '0;
      seq_shadow  <= '0;
      level_reg   <= '0;
      delta_len   <= '0;
      delta_acc   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      seq_counter <= seq_counter_next;
      seq_shadow  <= seq_shadow_next;
      level_reg   <= level_reg_next;
      delta_len   <= delta_len_next;
      delta_acc   <= delta_acc_next;
    end
  end

  a_seq_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SEQ |-> byte_count <= 3'd3)
    else $error("sequence byte count out of range");

  a_delta_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DELTA |-> byte_count < delta_len)
    else $error("delta byte count past delta length");

  a_eop_to_header: assert property (@(posedge clk) disable iff (rst)
    step && eop |=> phase == PH_HEADER && byte_count == 3'd0)
    else $error("parser not back at header after end of packet");

endmodule

/* rtl/log_record_header_parser.sv */
// Top level of the log record header parser: input register, parse logic, record register.
// Depends on lrhp_pkg and lrhp_parse.
`timescale 1ns / 1ps

// Accepts one packet byte per cycle while data_stall is low, and gives at most
// one record per byte. A byte is registered on entry and parsed once the record
// register is free; its record, if any, is loaded into the output register at
// the end of that cycle. With no stall on the record side the sustained rate is
// one byte per clock; data_stall follows rec_stall combinationally when both the
// input register and the record register are full.
module log_record_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  output logic        rec_valid,
  input  logic        rec_stall,
  output logic        record_kind,
  output logic [7:0]  msg_byte,
  output logic [2:0]  level,
  output logic [31:0] sequence_res,
  output logic [55:0] ts_delta,
  output logic        last_of_message
);
  import lrhp_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_eop;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  rec_t       res;

  assign out_free   = !rec_valid || !rec_stall;
  assign advance    = stage_valid && out_free;
  assign data_stall = stage_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!data_stall) begin
      stage_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      stage_byte <= data_byte;
      stage_eop  <= end_of_packet;
    end
  end

  lrhp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_in   (stage_byte),
    .eop       (stage_eop),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (out_free) begin
      rec_valid <= stage_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      record_kind     <= res.kind;
      msg_byte        <= res.msg;
      level           <= res.level;
      sequence_res    <= res.seq;
      ts_delta        <= res.delta;
      last_of_message <= res.last;
    end
  end

  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> stage_valid && rec_valid)
    else $error("input stalled with nothing held");

  a_end_record_form: assert property (@(posedge clk) disable iff (rst)
    rec_valid && record_kind == REC_END |-> last_of_message && msg_byte == 8'd0)
    else $error("malformed end record");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !rec_valid |-> !data_stall)
    else $error("input stalled while record register empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rec_valid && !stage_valid)
    else $error("pipeline not empty after reset");

endmodule
